// ===== src/ulci_pkg.sv =====
// ----------------------------------------------------------------------------
// ulci_pkg: shared definitions for the UART LED command interpreter
// Holds the line depth, reply kinds, reply text and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ulci_pkg;

  // Line buffer depth; one place is kept for the terminator.
  localparam int LINE_DEPTH = 64;
  localparam int FILL_W     = $clog2(LINE_DEPTH);

  // Special characters.
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;

  // Numeric limits.
  localparam logic [7:0] PCT_MAX   = 8'd100;
  localparam logic [6:0] PCT_RESET = 7'd50;

  // Reply kinds.
  localparam logic [2:0] RPL_ON      = 3'd0;
  localparam logic [2:0] RPL_OFF     = 3'd1;
  localparam logic [2:0] RPL_PWM     = 3'd2;
  localparam logic [2:0] RPL_STS_ON  = 3'd3;
  localparam logic [2:0] RPL_STS_OFF = 3'd4;

  // Reply text, first character in the top byte, padded to 13 bytes.
  localparam int MSG_W = 104;
  localparam logic [MSG_W-1:0] MSG_ON      = {"LED ON", CH_CR, CH_LF, 40'h0};
  localparam logic [MSG_W-1:0] MSG_OFF     = {"LED OFF", CH_CR, CH_LF, 32'h0};
  localparam logic [MSG_W-1:0] MSG_PWM     = {"PWM OK", CH_CR, CH_LF, 40'h0};
  localparam logic [MSG_W-1:0] MSG_STS_ON  = {"Status: ON", CH_CR, CH_LF, 8'h0};
  localparam logic [MSG_W-1:0] MSG_STS_OFF = {"Status: OFF", CH_CR, CH_LF};

  // Controller to datapath commands.
  typedef struct packed {
    logic take_byte;  // store an ordinary byte into the line
    logic line_end;   // handle the finished line
    logic advance;    // one reply character was transferred
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_bang;    // the offered byte ends the line
    logic hit;        // the finished line matches a command
    logic last;       // the current reply character is the final one
  } sts_t;

  // Character idx of the reply of the given kind.
  function automatic logic [7:0] reply_char(input logic [2:0] kind, input logic [3:0] idx);
    logic [MSG_W-1:0] msg;
    int               pos;
    case (kind)
      RPL_ON:      msg = MSG_ON;
      RPL_OFF:     msg = MSG_OFF;
      RPL_PWM:     msg = MSG_PWM;
      RPL_STS_ON:  msg = MSG_STS_ON;
      default:     msg = MSG_STS_OFF;
    endcase
    pos = MSG_W - 8 - 8 * int'(idx);
    if (pos < 0) begin
      pos = 0;
    end
    return msg[pos +: 8];
  endfunction

  // Number of characters in the reply of the given kind.
  function automatic logic [3:0] reply_len(input logic [2:0] kind);
    case (kind)
      RPL_ON:      return 4'd8;
      RPL_OFF:     return 4'd9;
      RPL_PWM:     return 4'd8;
      RPL_STS_ON:  return 4'd12;
      default:     return 4'd13;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== src/ulci_ctrl.sv =====
// ----------------------------------------------------------------------------
// ulci_ctrl: controller for the UART LED command interpreter
// Accepts bytes while idle and walks the reply out one character per
// transfer after a matched line.
// ----------------------------------------------------------------------------
`default_nettype none

module ulci_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  input  wire ulci_pkg::sts_t sts,
  output ulci_pkg::cmd_t      cmd
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_REPLY = 1'b1;

  logic state_r;
  logic state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (sts.is_bang) begin
            cmd.line_end = 1'b1;
            if (sts.hit) begin
              state_nxt = ST_REPLY;
            end
          end else begin
            cmd.take_byte = 1'b1;
          end
        end
      end
      ST_REPLY: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          cmd.advance = 1'b1;
          if (sts.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/ulci_dp.sv =====
// ----------------------------------------------------------------------------
// ulci_dp: datapath for the UART LED command interpreter
// Matches the line against the commands as its bytes arrive, keeps the LED
// flag, saved percent and duty compare, and holds the reply being sent.
// ----------------------------------------------------------------------------
`default_nettype none

module ulci_dp (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [7:0]     rx_byte,
  input  wire ulci_pkg::cmd_t cmd,
  output ulci_pkg::sts_t      sts,
  output logic [7:0]          tx_byte,
  output logic                tx_last,
  output logic [9:0]          duty_compare,
  output logic                led_on
);

  localparam int FW = ulci_pkg::FILL_W;

  // Command words, first character in the top byte.
  localparam int                          CMD_W   = 48;
  localparam logic [CMD_W-1:0]            CMD_ON  = {"ON", 32'h0};
  localparam logic [CMD_W-1:0]            CMD_OFF = {"OFF", 24'h0};
  localparam logic [CMD_W-1:0]            CMD_STS = "Status";
  localparam logic [CMD_W-1:0]            CMD_PWM = {"PWM:", 16'h0};
  localparam int                          LEN_ON  = 2;
  localparam int                          LEN_OFF = 3;
  localparam int                          LEN_STS = 6;
  localparam int                          LEN_PWM = 4;

  // PWM parse phases.
  localparam logic [1:0] PH_PREFIX = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_PCT    = 2'd2;
  localparam logic [1:0] PH_FAIL   = 2'd3;

  // Line matching state.
  logic [FW-1:0] fill_r, fill_nxt;
  logic          ended_r, ended_nxt;
  logic          on_ok_r, on_ok_nxt;
  logic          off_ok_r, off_ok_nxt;
  logic          sts_ok_r, sts_ok_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [7:0]    value_r, value_nxt;

  // Command results.
  logic          led_r, led_nxt;
  logic [6:0]    pct_r, pct_nxt;
  logic [9:0]    cmp_r, cmp_nxt;

  // Reply being sent.
  logic [2:0]    kind_r, kind_nxt;
  logic [3:0]    idx_r, idx_nxt;

  logic          m_on, m_off, m_sts, m_pwm;
  logic          is_digit;
  logic [9:0]    duty_new;

  // True when byte b equals character k of a command word of length len.
  function automatic logic word_ok(input logic [CMD_W-1:0] s, input int len,
                                   input logic [FW-1:0] k, input logic [7:0] b);
    int pos;
    pos = CMD_W - 8 - 8 * int'(k);
    if (int'(k) >= len || pos < 0) begin
      return 1'b0;
    end
    return b == s[pos +: 8];
  endfunction

  // Line decode at the terminator.
  assign m_on     = on_ok_r  && (int'(fill_r) == LEN_ON);
  assign m_off    = off_ok_r && (int'(fill_r) == LEN_OFF);
  assign m_sts    = sts_ok_r && (int'(fill_r) == LEN_STS);
  assign m_pwm    = (phase_r == PH_PCT) && (value_r <= ulci_pkg::PCT_MAX);
  assign is_digit = (rx_byte >= ulci_pkg::CH_ZERO) && (rx_byte <= ulci_pkg::CH_NINE);

  // Percent times ten as shift and add.
  assign duty_new = {pct_nxt, 3'b000} + {2'b00, pct_nxt, 1'b0};

  assign sts.is_bang = (rx_byte == ulci_pkg::CH_BANG);
  assign sts.hit     = m_on || m_off || m_sts || m_pwm;
  assign sts.last    = (idx_r == ulci_pkg::reply_len(kind_r) - 4'd1);

  assign tx_byte      = ulci_pkg::reply_char(kind_r, idx_r);
  assign tx_last      = sts.last;
  assign duty_compare = cmp_r;
  assign led_on       = led_r;

  // Next-state logic for matcher, settings and reply.
  always_comb begin
    fill_nxt   = fill_r;
    ended_nxt  = ended_r;
    on_ok_nxt  = on_ok_r;
    off_ok_nxt = off_ok_r;
    sts_ok_nxt = sts_ok_r;
    phase_nxt  = phase_r;
    value_nxt  = value_r;
    led_nxt    = led_r;
    pct_nxt    = pct_r;
    cmp_nxt    = cmp_r;
    kind_nxt   = kind_r;
    idx_nxt    = idx_r;

    if (cmd.take_byte && !ended_r && (fill_r < FW'(ulci_pkg::LINE_DEPTH - 1))) begin
      if (rx_byte == 8'h00) begin
        // A zero byte ends the text; later bytes cannot change the match.
        ended_nxt = 1'b1;
      end else begin
        fill_nxt   = fill_r + FW'(1);
        on_ok_nxt  = on_ok_r  && word_ok(CMD_ON,  LEN_ON,  fill_r, rx_byte);
        off_ok_nxt = off_ok_r && word_ok(CMD_OFF, LEN_OFF, fill_r, rx_byte);
        sts_ok_nxt = sts_ok_r && word_ok(CMD_STS, LEN_STS, fill_r, rx_byte);
        case (phase_r)
          PH_PREFIX: begin
            if (!word_ok(CMD_PWM, LEN_PWM, fill_r, rx_byte)) begin
              phase_nxt = PH_FAIL;
            end else if (int'(fill_r) == LEN_PWM - 1) begin
              phase_nxt = PH_DIGITS;
            end
          end
          PH_DIGITS: begin
            if (is_digit) begin
              value_nxt = 8'(value_r * 8'd10 + {4'h0, rx_byte[3:0]});
            end else if (rx_byte == ulci_pkg::CH_PERCENT) begin
              phase_nxt = PH_PCT;
            end else begin
              phase_nxt = PH_FAIL;
            end
          end
          PH_PCT: begin
            phase_nxt = PH_FAIL;
          end
          default: begin
            phase_nxt = PH_FAIL;
          end
        endcase
      end
    end

    if (cmd.line_end) begin
      // Apply the command and pick the reply.
      if (m_on) begin
        led_nxt  = 1'b1;
        cmp_nxt  = duty_new;
        kind_nxt = ulci_pkg::RPL_ON;
      end else if (m_off) begin
        led_nxt  = 1'b0;
        cmp_nxt  = 10'd0;
        kind_nxt = ulci_pkg::RPL_OFF;
      end else if (m_sts) begin
        kind_nxt = led_r ? ulci_pkg::RPL_STS_ON : ulci_pkg::RPL_STS_OFF;
      end else if (m_pwm) begin
        pct_nxt  = value_r[6:0];
        kind_nxt = ulci_pkg::RPL_PWM;
        if (led_r) begin
          cmp_nxt = duty_new;
        end
      end
      idx_nxt    = 4'd0;
      // Start a fresh line.
      fill_nxt   = '0;
      ended_nxt  = 1'b0;
      on_ok_nxt  = 1'b1;
      off_ok_nxt = 1'b1;
      sts_ok_nxt = 1'b1;
      phase_nxt  = PH_PREFIX;
      value_nxt  = 8'd0;
    end

    if (cmd.advance) begin
      idx_nxt = idx_r + 4'd1;
    end
  end

  // Control and settings registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      ended_r  <= 1'b0;
      on_ok_r  <= 1'b1;
      off_ok_r <= 1'b1;
      sts_ok_r <= 1'b1;
      phase_r  <= PH_PREFIX;
      value_r  <= 8'd0;
      led_r    <= 1'b0;
      pct_r    <= ulci_pkg::PCT_RESET;
      cmp_r    <= 10'd0;
    end else begin
      fill_r   <= fill_nxt;
      ended_r  <= ended_nxt;
      on_ok_r  <= on_ok_nxt;
      off_ok_r <= off_ok_nxt;
      sts_ok_r <= sts_ok_nxt;
      phase_r  <= phase_nxt;
      value_r  <= value_nxt;
      led_r    <= led_nxt;
      pct_r    <= pct_nxt;
      cmp_r    <= cmp_nxt;
    end
  end

  // Reply pointer registers.
  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    idx_r  <= idx_nxt;
  end

endmodule

`default_nettype wire

// ===== src/uart_led_command_interpreter_unit.sv =====
// ----------------------------------------------------------------------------
// uart_led_command_interpreter_unit: top level of the LED command interpreter
// Collects received characters into a command line and answers ON, OFF,
// Status and PWM:<n>% commands with a text reply, one character per transfer.
//
//   Channel  Direction  tdata bits (low first)                     tlast
//   in_      slave      rx_byte[7:0]                              -
//   out_     master     tx_byte[7:0], duty_compare[17:8],         tx_last
//                       led_on[18], zero[23:19]
//
// An ordinary byte is taken while no reply is pending. A line end with a
// matching command is followed by the reply, one character per cycle (8 to 13
// characters) while out_tready is high; the reply counter in the datapath sets this.
// in_tready is low while a reply is being sent; out_tready low holds it.
// Synchronous active-low reset clears the line, turns the LED off, sets the
// saved percent to fifty and the duty compare to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_led_command_interpreter_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // rx_byte[7:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // tx_byte[7:0], duty_compare[17:8], led_on[18]
  output logic             out_tlast
);

  ulci_pkg::cmd_t cmd;
  ulci_pkg::sts_t sts;
  logic [7:0]     tx_byte;
  logic [9:0]     duty_compare;
  logic           led_on;

  // Sequencing of byte intake and reply transfer.
  ulci_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Matching, settings and reply text.
  ulci_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .rx_byte      (in_tdata),
    .cmd          (cmd),
    .sts          (sts),
    .tx_byte      (tx_byte),
    .tx_last      (out_tlast),
    .duty_compare (duty_compare),
    .led_on       (led_on)
  );

  // Result packing.
  assign out_tdata = {5'b00000, led_on, duty_compare, tx_byte};

endmodule

`default_nettype wire
